// File: hdl/oale_pkg.sv
// ============================================================================
// oale_pkg
// Shared types and constants of the ordered array list engine: store size,
// field widths, action and status codes, request and result structs.
// ============================================================================
`default_nettype none

package oale_pkg;

    // Store geometry
    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths
    localparam int ACT_W  = 3;
    localparam int POS_W  = 9;
    localparam int WORD_W = 32;
    localparam int STAT_W = 2;
    localparam int IDX_W  = 9;
    localparam int LEN_W  = 9;

    // Common width for position and count compares
    localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_GET    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_LOCATE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_PRIOR  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_NEXT   = 3'd5;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd6;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_POS   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_MOVE,
        S_SCAN,
        S_NEXT
    } state_t;

    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [WORD_W-1:0] data_out;
        logic [IDX_W-1:0]         found_index;
        logic [LEN_W-1:0]         list_length;
        logic                     is_empty;
    } result_t;

endpackage

`default_nettype wire

// File: hdl/ordered_array_list_engine.sv
// ============================================================================
// ordered_array_list_engine
// Ordered list of signed words in a single-port-write, registered-read store
// with a length count: insert, delete, get, locate, prior, next and clear.
// ============================================================================
//
//  Channel   Signals               Transfer
//  --------  --------------------  ----------------------------------------
//  request   start, busy, request  taken at a rising edge with start & !busy
//  result    done, result          one cycle, strobed by done, never stalled
//
//  Errors, clear and unused actions keep busy low and strobe done in the cycle
//  after acceptance. Otherwise busy stays high while insert shifts later entries
//  right, delete reads its entry and shifts later entries left, get reads its
//  entry and locate, prior and next scan the list. Moved or searched entries
//  share the store's single read port, pipelined against its write port; done
//  rises in the same cycle that busy falls.
//  Reset clears the count and the sequencer; the store is not cleared.
//  busy is high while a transaction walks the store; done never waits.
// ============================================================================
`default_nettype none

module ordered_array_list_engine
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire oale_pkg::request_t request,
    output logic                    done,
    output oale_pkg::result_t       result
);

    localparam int ADDR_W = oale_pkg::ADDR_W;
    localparam int CNT_W  = oale_pkg::CNT_W;
    localparam int CMP_W  = oale_pkg::CMP_W;
    localparam int POS_W  = oale_pkg::POS_W;
    localparam int WORD_W = oale_pkg::WORD_W;

    // Element store
    logic [WORD_W-1:0] mem [oale_pkg::CAPACITY];
    logic [WORD_W-1:0] mem_rdata_reg;
    logic [ADDR_W-1:0] mem_raddr;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_we;

    // Control and working registers
    oale_pkg::state_t          state_reg, state_next;
    logic [oale_pkg::ACT_W-1:0] act_reg, act_next;
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic [WORD_W-1:0]         key_reg, key_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          ptr_reg, ptr_next;
    logic [CNT_W-1:0]          lim_reg, lim_next;
    logic [CNT_W-1:0]          tag_reg, tag_next;
    logic                      pend_reg, pend_next;
    logic [WORD_W-1:0]         prev_reg, prev_next;
    logic [WORD_W-1:0]         hold_reg, hold_next;
    oale_pkg::result_t         res_reg, res_next;
    logic                      done_reg, done_next;

    // Finish request from the sequencer
    logic                          fin;
    logic [oale_pkg::STAT_W-1:0]   fin_status;
    logic [WORD_W-1:0]             fin_data;
    logic [CNT_W-1:0]              fin_idx;
    logic [CNT_W-1:0]              fin_count;

    // Helper arithmetic
    logic [CMP_W-1:0] req_pos_x, pos_x, cnt_x, ptr_x, lim_x, tag_inc_x;
    logic [CNT_W-1:0] ptr_dec, ptr_inc, tag_inc, tag_dec, pos_dec;
    logic             match;

    assign req_pos_x = CMP_W'(request.position);
    assign pos_x     = CMP_W'(pos_reg);
    assign cnt_x     = CMP_W'(count_reg);
    assign ptr_x     = CMP_W'(ptr_reg);
    assign lim_x     = CMP_W'(lim_reg);
    assign tag_inc_x = CMP_W'(tag_reg) + CMP_W'(1);
    assign ptr_dec   = ptr_reg - CNT_W'(1);
    assign ptr_inc   = ptr_reg + CNT_W'(1);
    assign tag_inc   = tag_reg + CNT_W'(1);
    assign tag_dec   = tag_reg - CNT_W'(1);
    assign pos_dec   = CNT_W'(pos_x - CMP_W'(1));
    assign match     = pend_reg && (mem_rdata_reg == key_reg);

    // Store: one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    // Hold state and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= oale_pkg::S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        pos_reg  <= pos_next;
        key_reg  <= key_next;
        ptr_reg  <= ptr_next;
        lim_reg  <= lim_next;
        tag_reg  <= tag_next;
        prev_reg <= prev_next;
        hold_reg <= hold_next;
        res_reg  <= res_next;
    end

    // Sequence each transaction over the store
    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        pos_next   = pos_reg;
        key_next   = key_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        lim_next   = lim_reg;
        tag_next   = tag_reg;
        pend_next  = pend_reg;
        prev_next  = prev_reg;
        hold_next  = hold_reg;
        res_next   = res_reg;
        done_next  = 1'b0;

        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = key_reg;
        mem_raddr  = ptr_reg[ADDR_W-1:0];

        fin        = 1'b0;
        fin_status = oale_pkg::STAT_OK;
        fin_data   = '0;
        fin_idx    = '0;
        fin_count  = count_reg;

        unique case (state_reg)
            oale_pkg::S_IDLE:
            begin
                if (start)
                begin
                    act_next  = request.action;
                    pos_next  = request.position;
                    key_next  = request.value;
                    pend_next = 1'b0;
                    unique case (request.action)
                        oale_pkg::ACT_INSERT:
                        begin
                            if (req_pos_x == '0 || req_pos_x > cnt_x + CMP_W'(1))
                            begin
                                fin        = 1'b1;
                                fin_status = oale_pkg::STAT_BAD_POS;
                            end
                            else if (cnt_x == CMP_W'(oale_pkg::CAPACITY))
                            begin
                                fin        = 1'b1;
                                fin_status = oale_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ptr_next   = count_reg;
                                state_next = oale_pkg::S_INS;
                            end
                        end
                        oale_pkg::ACT_DELETE,
                        oale_pkg::ACT_GET:
                        begin
                            if (req_pos_x == '0 || req_pos_x > cnt_x)
                            begin
                                fin        = 1'b1;
                                fin_status = oale_pkg::STAT_BAD_POS;
                            end
                            else
                            begin
                                ptr_next   = CNT_W'(req_pos_x - CMP_W'(1));
                                lim_next   = (request.action == oale_pkg::ACT_DELETE)
                                             ? count_reg : CNT_W'(req_pos_x);
                                state_next = oale_pkg::S_MOVE;
                            end
                        end
                        oale_pkg::ACT_LOCATE,
                        oale_pkg::ACT_PRIOR,
                        oale_pkg::ACT_NEXT:
                        begin
                            ptr_next   = '0;
                            lim_next   = count_reg;
                            state_next = oale_pkg::S_SCAN;
                        end
                        oale_pkg::ACT_CLEAR:
                        begin
                            fin       = 1'b1;
                            fin_count = '0;
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            // Shift entries right, top down, then drop the key into place
            oale_pkg::S_INS:
            begin
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = tag_inc[ADDR_W-1:0];
                    mem_wdata = mem_rdata_reg;
                end
                if (ptr_x >= pos_x)
                begin
                    mem_raddr = ptr_dec[ADDR_W-1:0];
                    tag_next  = ptr_dec;
                    ptr_next  = ptr_dec;
                    pend_next = 1'b1;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pos_dec[ADDR_W-1:0];
                    mem_wdata = key_reg;
                    fin       = 1'b1;
                    fin_count = count_reg + CNT_W'(1);
                end
            end

            // Read the addressed entry, then shift later entries left on delete
            oale_pkg::S_MOVE:
            begin
                if (pend_reg)
                begin
                    if (tag_reg == pos_dec)
                    begin
                        hold_next = mem_rdata_reg;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = tag_dec[ADDR_W-1:0];
                        mem_wdata = mem_rdata_reg;
                    end
                end
                if (ptr_x < lim_x)
                begin
                    mem_raddr = ptr_reg[ADDR_W-1:0];
                    tag_next  = ptr_reg;
                    ptr_next  = ptr_inc;
                    pend_next = 1'b1;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    fin       = 1'b1;
                    fin_data  = hold_reg;
                    fin_count = (act_reg == oale_pkg::ACT_DELETE)
                                ? count_reg - CNT_W'(1) : count_reg;
                end
            end

            // Walk the list for the first usable match
            oale_pkg::S_SCAN:
            begin
                if (pend_reg)
                begin
                    prev_next = mem_rdata_reg;
                end
                if (match && act_reg == oale_pkg::ACT_LOCATE)
                begin
                    fin     = 1'b1;
                    fin_idx = tag_inc;
                end
                else if (match && act_reg == oale_pkg::ACT_PRIOR && tag_reg != '0)
                begin
                    fin      = 1'b1;
                    fin_data = prev_reg;
                end
                else
                begin
                    if (ptr_x < lim_x)
                    begin
                        mem_raddr = ptr_reg[ADDR_W-1:0];
                        tag_next  = ptr_reg;
                        ptr_next  = ptr_inc;
                        pend_next = 1'b1;
                    end
                    if (match && act_reg == oale_pkg::ACT_NEXT && tag_inc_x < cnt_x)
                    begin
                        state_next = oale_pkg::S_NEXT;
                    end
                    else if (ptr_x >= lim_x && !pend_reg)
                    begin
                        fin        = 1'b1;
                        fin_status = oale_pkg::STAT_NOT_FOUND;
                    end
                    else if (ptr_x >= lim_x)
                    begin
                        pend_next = 1'b0;
                    end
                end
            end

            // Successor read issued with the match arrives now
            oale_pkg::S_NEXT:
            begin
                fin      = 1'b1;
                fin_data = mem_rdata_reg;
            end

            default:
            begin
                state_next = oale_pkg::S_IDLE;
            end
        endcase

        // Register the result transaction and return to idle
        if (fin)
        begin
            res_next.status      = fin_status;
            res_next.data_out    = fin_data;
            res_next.found_index = oale_pkg::IDX_W'(fin_idx);
            res_next.list_length = oale_pkg::LEN_W'(fin_count);
            res_next.is_empty    = (fin_count == '0);
            done_next            = 1'b1;
            count_next           = fin_count;
            pend_next            = 1'b0;
            state_next           = oale_pkg::S_IDLE;
        end
    end

    assign busy   = (state_reg != oale_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

`ifndef NO_ASSERTIONS
    // A result is only shown once the sequencer is back to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // An accepted transaction either finishes at once or keeps the block busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted transaction dropped");

    // Length never exceeds the store
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(oale_pkg::CAPACITY))
        else $error("count beyond capacity");

    // Empty flag agrees with the reported length
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.is_empty == (result.list_length == '0)))
        else $error("empty flag mismatch");
`endif

endmodule

`default_nettype wire
